[design/utf8_stream_decoder_macros.svh]
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Define ASSERT_OFF to compile every check away. No other dependencies.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted (active low).
`define UTF8SD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define UTF8SD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UTF8SD_ASSERT(lbl, clk, rst_n, prop, msg)
`define UTF8SD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[design/utf8sd_pkg.sv]
// Types and constants shared by the UTF-8 stream decoder modules.
// No dependencies.
package utf8sd_pkg;

    // Operation classes produced by the front classifier
    typedef enum logic [2:0] {
        K_END   = 3'd0,
        K_ZERO  = 3'd1,
        K_LEAD  = 3'd2,
        K_BAD   = 3'd3,
        K_TRAIL = 3'd4,
        K_ASCII = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SKIPPED    = 2'd1,
        ST_NO_MAPPING = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  lead_len;  // trailers a lead byte opens
        logic [6:0]  payload;   // masked data bits of the byte
    } t_op;

    typedef struct packed {
        logic [20:0] code_point;
        t_status     status;
        logic [15:0] bytes_used;
    } t_result;

    localparam logic [7:0]  LEAD_MASK     = 8'hC0;
    localparam logic [15:0] OUT_COUNT_MAX = 16'hFFFF;
    localparam logic [20:0] CP_MAX        = 21'h10FFFF;
    localparam logic [20:0] SURR_LO       = 21'h00D800;
    localparam logic [20:0] SURR_HI       = 21'h00DFFF;
    localparam int          QUEUE_DEPTH   = 2;

endpackage

[design/utf8sd_queue.sv]
// Small register FIFO used between decoder stages and on the result side.
// Depends on utf8_stream_decoder_macros.svh for its checks.
`include "utf8_stream_decoder_macros.svh"
module utf8sd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `UTF8SD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue overfilled")
    `UTF8SD_ASSERT(a_push_pop_hold, i_clk, i_rst_n, (do_push && do_pop) |=> $stable(r_count), "queue count moved on push and pop")
    `UTF8SD_ASSERT(a_full_empty, i_clk, i_rst_n, !(o_full && o_empty), "queue both full and empty")

endmodule

[design/utf8sd_front.sv]
// Front end: accepts byte or end-of-buffer transactions and classifies them.
// Depends on utf8sd_pkg and utf8sd_queue (operation queue to the back end).
module utf8sd_front
    import utf8sd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_mode,
    input  logic [7:0] i_byte_value,
    output logic       o_full,
    input  logic       i_op_pop,
    output t_op        o_op,
    output logic       o_op_empty
);
    t_op op;

    always_comb begin
        op.kind     = K_ASCII;
        op.lead_len = 2'd0;
        op.payload  = i_byte_value[6:0];
        priority if (i_mode) begin
            op.kind    = K_END;
            op.payload = '0;
        end else if (i_byte_value == 8'h00) begin
            op.kind = K_ZERO;
        end else if ((i_byte_value & LEAD_MASK) == LEAD_MASK) begin
            op.kind = K_LEAD;
            priority if (!i_byte_value[5]) begin
                op.lead_len = 2'd1;
                op.payload  = {2'b00, i_byte_value[4:0]};
            end else if (!i_byte_value[4]) begin
                op.lead_len = 2'd2;
                op.payload  = {3'b000, i_byte_value[3:0]};
            end else if (!i_byte_value[3]) begin
                op.lead_len = 2'd3;
                op.payload  = {4'b0000, i_byte_value[2:0]};
            end else begin
                // F8-FF: never valid in UTF-8
                op.kind    = K_BAD;
                op.payload = '0;
            end
        end else if (i_byte_value[7]) begin
            op.kind    = K_TRAIL;
            op.payload = {1'b0, i_byte_value[5:0]};
        end else begin
            op.kind = K_ASCII;
        end
    end

    utf8sd_queue #(
        .WIDTH ($bits(t_op)),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (op),
        .o_full  (o_full),
        .i_pop   (i_op_pop),
        .o_data  (o_op),
        .o_empty (o_op_empty)
    );

endmodule

[design/utf8sd_back.sv]
// Back end: holds the decode state and turns classified operations into results.
// Depends on utf8sd_pkg and utf8_stream_decoder_macros.svh.
`include "utf8_stream_decoder_macros.svh"
module utf8sd_back
    import utf8sd_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_op     i_op,
    input  logic    i_op_empty,
    output logic    o_op_pop,
    output t_result o_res,
    output logic    o_res_push,
    input  logic    i_res_full
);
    localparam int WW = COUNT_BITS + 16;

    logic [1:0]            r_pend, n_pend;
    logic [20:0]           r_partial, n_partial;
    logic                  r_flag, n_flag;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [COUNT_BITS-1:0] count_inc;
    logic [20:0]           trail_code;
    logic [1:0]            pend_dec;
    logic                  go, emit, cp_valid;

    function automatic logic [15:0] sat_used(input logic [COUNT_BITS-1:0] c);
        logic [WW-1:0] wide;
        wide = WW'(c);
        return (wide > WW'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX : wide[15:0];
    endfunction

    assign go         = !i_op_empty && !i_res_full;
    assign o_op_pop   = go;
    assign o_res_push = emit;
    assign count_inc  = (&r_count) ? r_count : r_count + 1'b1;
    assign trail_code = {r_partial[14:0], i_op.payload[5:0]};
    assign pend_dec   = r_pend - 2'd1;
    assign cp_valid   = (trail_code <= CP_MAX) &&
                        !((trail_code >= SURR_LO) && (trail_code <= SURR_HI));

    always_comb begin
        n_pend    = r_pend;
        n_partial = r_partial;
        n_flag    = r_flag;
        n_count   = r_count;
        emit      = 1'b0;
        o_res     = '0;
        if (go) begin
            unique case (i_op.kind)
                K_END: begin
                    emit             = 1'b1;
                    o_res.status     = r_flag ? ST_NO_MAPPING : ST_NOT_FOUND;
                    o_res.bytes_used = sat_used(r_count);
                end
                K_ZERO: begin
                    emit             = 1'b1;
                    o_res.status     = r_flag ? ST_SKIPPED : ST_OK;
                    o_res.bytes_used = sat_used(count_inc);
                end
                K_LEAD: begin
                    n_count   = count_inc;
                    n_flag    = r_flag || (r_pend != 2'd0);
                    n_pend    = i_op.lead_len;
                    n_partial = {14'd0, i_op.payload};
                end
                K_BAD: begin
                    n_count   = count_inc;
                    n_flag    = 1'b1;
                    n_pend    = 2'd0;
                    n_partial = '0;
                end
                K_TRAIL: begin
                    n_count = count_inc;
                    if (r_pend == 2'd0) begin
                        n_flag = 1'b1;  // stray trailer
                    end else begin
                        n_pend = pend_dec;
                        if (pend_dec != 2'd0) begin
                            n_partial = trail_code;
                        end else begin
                            n_partial = '0;
                            // surrogates and out-of-range scalars vanish
                            if (cp_valid) begin
                                emit             = 1'b1;
                                o_res.code_point = trail_code;
                                o_res.status     = r_flag ? ST_SKIPPED : ST_OK;
                                o_res.bytes_used = sat_used(count_inc);
                            end
                        end
                    end
                end
                K_ASCII: begin
                    emit             = 1'b1;
                    o_res.code_point = {14'd0, i_op.payload};
                    o_res.status     = (r_flag || (r_pend != 2'd0)) ? ST_SKIPPED : ST_OK;
                    o_res.bytes_used = sat_used(count_inc);
                end
                default: begin
                end
            endcase
        end
        if (emit) begin
            n_pend    = 2'd0;
            n_partial = '0;
            n_flag    = 1'b0;
            n_count   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 2'd0;
            r_partial <= '0;
            r_flag    <= 1'b0;
            r_count   <= '0;
        end else begin
            r_pend    <= n_pend;
            r_partial <= n_partial;
            r_flag    <= n_flag;
            r_count   <= n_count;
        end
    end

    `UTF8SD_ASSERT(a_idle_partial, i_clk, i_rst_n, (r_pend == 2'd0) |-> (r_partial == '0), "partial code left without pending trailers")
    `UTF8SD_ASSERT(a_push_needs_op, i_clk, i_rst_n, o_res_push |-> o_op_pop, "result pushed without an operation")
    `UTF8SD_ASSERT(a_end_emits, i_clk, i_rst_n, (o_op_pop && (i_op.kind == K_END)) |-> o_res_push, "end of buffer gave no result")
    `UTF8SD_ASSERT(a_emit_clears, i_clk, i_rst_n, o_res_push |=> ((r_pend == 2'd0) && !r_flag && (r_count == '0)), "state not cleared after result")

endmodule

[design/utf8_stream_decoder.sv]
// Top level of the byte-serial UTF-8 stream decoder.
// Depends on utf8sd_pkg, utf8sd_front, utf8sd_back and utf8sd_queue.
//
//   channel  | direction | handshake      | payload
//   ---------+-----------+----------------+------------------------------------
//   input    | in        | i_push, o_full | i_mode, i_byte_value
//   result   | out       | o_empty, i_pop | o_code_point, o_status, o_bytes_used
//
// One byte or end-of-buffer transaction per cycle while o_full is low; the back
// end updates its state per popped operation. Each input waits in the operation
// queue and its result in the result queue, before o_empty falls.
// Synchronous active-low reset clears the queues and the decode state.
// A full result queue stalls the back end; the operation queue then fills and
// raises o_full.
module utf8_stream_decoder
    import utf8sd_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_mode,
    input  logic [7:0]  i_byte_value,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [20:0] o_code_point,
    output logic [1:0]  o_status,
    output logic [15:0] o_bytes_used
);
    t_op     op;
    logic    op_empty, op_pop;
    t_result res, res_out;
    logic    res_push, res_full;

    utf8sd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_mode       (i_mode),
        .i_byte_value (i_byte_value),
        .o_full       (o_full),
        .i_op_pop     (op_pop),
        .o_op         (op),
        .o_op_empty   (op_empty)
    );

    utf8sd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .i_op_empty (op_empty),
        .o_op_pop   (op_pop),
        .o_res      (res),
        .o_res_push (res_push),
        .i_res_full (res_full)
    );

    utf8sd_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (res_out),
        .o_empty (o_empty)
    );

    assign o_code_point = res_out.code_point;
    assign o_status     = res_out.status;
    assign o_bytes_used = res_out.bytes_used;

endmodule

[verif/testbench.sv]
// Self-checking testbench for utf8_stream_decoder: a scoreboard class predicts each
// decode from the accepted byte stream and checks results in order at the pop side.
// Depends on utf8sd_pkg and the decoder RTL.
module testbench;
    import utf8sd_pkg::*;

    localparam int          CNT_W      = 16;
    localparam int unsigned CNT_MAX    = 32'((64'd1 << CNT_W) - 64'd1);
    localparam int          LATENCY    = 2;
    localparam int          CYCLE_LIMIT = 100000;
    localparam int          PHASE_ITEMS = 300;

    class result_scoreboard;
        bit [1:0]    trail_left;
        bit [20:0]   code_acc;
        bit          warned;
        int unsigned byte_cnt;
        t_result     expected_q[$];
        int          failures;
        int          reported;

        function new();
            clear_state();
            failures = 0;
            reported = 0;
        endfunction

        function void clear_state();
            trail_left = 2'd0;
            code_acc   = 21'd0;
            warned     = 1'b0;
            byte_cnt   = 0;
        endfunction

        function void push_result(logic [20:0] cp, t_status st);
            t_result r;
            r.code_point = cp;
            r.status     = st;
            r.bytes_used = (byte_cnt > OUT_COUNT_MAX) ? OUT_COUNT_MAX : byte_cnt[15:0];
            expected_q.push_back(r);
            clear_state();
        endfunction

        function t_kind classify(logic m, logic [7:0] b);
            if (m)
                return K_END;
            if (b == 8'h00)
                return K_ZERO;
            if ((b & LEAD_MASK) == LEAD_MASK)
                return (b[7:3] == 5'b11111) ? K_BAD : K_LEAD;
            if (b[7])
                return K_TRAIL;
            return K_ASCII;
        endfunction

        // Predict the effect of one accepted input transaction.
        function void note_input(logic m, logic [7:0] b);
            logic [20:0] cp;
            t_kind       kind;
            kind = classify(m, b);
            if (kind != K_END && byte_cnt < CNT_MAX)
                byte_cnt++;
            case (kind)
                K_END: push_result(21'd0, warned ? ST_NO_MAPPING : ST_NOT_FOUND);
                K_ZERO: push_result(21'd0, warned ? ST_SKIPPED : ST_OK);
                K_LEAD: begin
                    if (trail_left != 2'd0)
                        warned = 1'b1;
                    if (!b[5]) begin
                        trail_left = 2'd1;
                        code_acc   = {16'd0, b[4:0]};
                    end else if (!b[4]) begin
                        trail_left = 2'd2;
                        code_acc   = {17'd0, b[3:0]};
                    end else begin
                        trail_left = 2'd3;
                        code_acc   = {18'd0, b[2:0]};
                    end
                end
                K_BAD: begin
                    warned     = 1'b1;
                    trail_left = 2'd0;
                    code_acc   = 21'd0;
                end
                K_TRAIL: begin
                    if (trail_left == 2'd0) begin
                        warned = 1'b1;
                    end else begin
                        cp = {code_acc[14:0], b[5:0]};
                        trail_left--;
                        if (trail_left != 2'd0) begin
                            code_acc = cp;
                        end else begin
                            code_acc = 21'd0;
                            // surrogates and out-of-range scalars vanish silently
                            if (cp <= CP_MAX && !(cp >= SURR_LO && cp <= SURR_HI))
                                push_result(cp, warned ? ST_SKIPPED : ST_OK);
                        end
                    end
                end
                K_ASCII: begin
                    if (trail_left != 2'd0) begin
                        warned     = 1'b1;
                        trail_left = 2'd0;
                    end
                    push_result({14'd0, b[6:0]}, warned ? ST_SKIPPED : ST_OK);
                end
                default: ;
            endcase
        endfunction

        function void log_failure(string msg);
            failures++;
            if (reported < 10)
                $display("%s", msg);
            reported++;
        endfunction

        function void check_result(logic [20:0] cp, logic [1:0] st, logic [15:0] used);
            t_result want;
            if (expected_q.size() == 0) begin
                log_failure($sformatf("unexpected result: cp=%06h st=%0d used=%0d",
                                      cp, st, used));
                return;
            end
            want = expected_q.pop_front();
            if (cp !== want.code_point || st !== want.status || used !== want.bytes_used)
                log_failure($sformatf(
                    "mismatch: expected cp=%06h st=%0d used=%0d, got cp=%06h st=%0d used=%0d",
                    want.code_point, want.status, want.bytes_used, cp, st, used));
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
                log_failure($sformatf("%0d results never arrived", expected_q.size()));
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_push       = 1'b0;
    logic        i_mode       = 1'b0;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_pop        = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [20:0] o_code_point;
    logic [1:0]  o_status;
    logic [15:0] o_bytes_used;

    result_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int items_sent = 0;
    int cycle_cnt = 0;

    utf8_stream_decoder #(
        .COUNT_BITS(CNT_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_mode      (i_mode),
        .i_byte_value(i_byte_value),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_code_point(o_code_point),
        .o_status    (o_status),
        .o_bytes_used(o_bytes_used)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Pop side: random stalls, plus a long hold-off when requested.
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_pop <= 1'b0;
                hold_cycles--;
            end else begin
                i_pop <= ($urandom_range(99) >= recv_stall_pct);
            end
            @(posedge i_clk);
            if (i_pop && !o_empty)
                sb.check_result(o_code_point, o_status, o_bytes_used);
        end
    end

    task automatic send_item(input logic m, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_push <= 1'b0;
        end
        @(negedge i_clk);
        i_push       <= 1'b1;
        i_mode       <= m;
        i_byte_value <= b;
        do @(posedge i_clk); while (o_full);
        sb.note_input(m, b);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(1'b0, b);
    endtask

    task automatic send_end();
        send_item(1'b1, 8'($urandom));
    endtask

    // Lead byte of a units-long sequence followed by the given number of trailers.
    task automatic send_multi(input int units, input int trailers);
        logic [7:0] r;
        r = 8'($urandom);
        case (units)
            2:       send_byte({3'b110, r[4:0]});
            3:       send_byte({4'b1110, r[3:0]});
            default: send_byte({5'b11110, r[2:0]});
        endcase
        repeat (trailers) send_byte({2'b10, 6'($urandom)});
    endtask

    task automatic send_random_char();
        int sel;
        int units;
        sel = $urandom_range(99);
        if (sel < 30) begin
            send_byte(8'($urandom_range(1, 127)));
        end else if (sel < 45) begin
            send_multi(2, 1);
        end else if (sel < 60) begin
            send_multi(3, 2);
        end else if (sel < 72) begin
            send_multi(4, 3);
        end else if (sel < 76) begin
            send_byte(8'hED);
            send_byte({3'b101, 5'($urandom)});
            send_byte({2'b10, 6'($urandom)});
        end else if (sel < 80) begin
            send_byte(8'h00);
        end else if (sel < 86) begin
            send_end();
        end else if (sel < 93) begin
            send_byte(8'($urandom));
        end else begin
            // truncated sequence, then whatever comes next
            units = $urandom_range(2, 4);
            send_multi(units, $urandom_range(0, units - 2));
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int send_pct[4];
        int stall_pct[4];
        send_pct  = '{0, 51, 0, 23};
        stall_pct = '{0, 0, 51, 23};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send_end();                         // nothing consumed: not found, zero bytes
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'hC3); send_byte(8'hA9);
        send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
        send_byte(8'hF4); send_byte(8'h8F); send_byte(8'hBF); send_byte(8'hBF);
        send_byte(8'hED); send_byte(8'hA0); send_byte(8'h80);   // surrogate
        send_byte(8'hF4); send_byte(8'h90); send_byte(8'h80); send_byte(8'h80);
        send_byte(8'h80);                   // stray trailer
        send_byte(8'h01);
        send_byte(8'hC3); send_byte(8'hC3); send_byte(8'hA9);   // lead inside a sequence
        send_byte(8'hE2); send_byte(8'h41); // ascii cuts a sequence
        send_byte(8'hE2); send_byte(8'h82); send_byte(8'h00);   // zero cuts without warning
        send_byte(8'hF8); send_byte(8'hFF); send_end();
        drain();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = stall_pct[p];
            if (p == 0)
                hold_cycles = 80;          // back up the queues until o_full rises
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
                send_random_char();
            send_end();
            drain();
        end

        recv_stall_pct = 0;
        repeat (LATENCY + 8) @(posedge i_clk);
        sb.close_out();
        if (sb.failures == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
